>>> rtl/core/ogl_pkg.sv
// Package for the occupancy grid line draw block: grid geometry, codes, types and
// the constant tables used by the line stepping units.
// Used by every module under rtl/core; has no dependencies of its own.
package ogl_pkg;

  // Grid geometry: GRID_SIZE x GRID_SIZE cells, index x + y * GRID_SIZE.
  localparam int GRID_SIZE = 64;
  localparam int DEPTH     = GRID_SIZE * GRID_SIZE;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(GRID_SIZE);

  // Coordinate fields are six bits wide on the ports.
  localparam int COORD_W = 6;
  localparam int COORD_N = 2 ** COORD_W;

  // Remainder of the rounding accumulator stays below 4 * GRID_SIZE.
  localparam int REM_W = $clog2(4 * GRID_SIZE);

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [1:0]         cell_t;
  typedef logic [1:0]         func_t;

  // Request codes.
  localparam func_t FN_READ  = 2'd0;
  localparam func_t FN_WRITE = 2'd1;
  localparam func_t FN_DRAW  = 2'd2;

  // Cell states (agent is 1 and obstacle is 2; both are stored as given).
  localparam cell_t STATE_FREE = 2'd0;
  localparam cell_t STATE_RSVD = 2'd3;

  // Controller states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_LINE,
    ST_END,
    ST_FINISH
  } ctrl_state_t;

  // Memory request from the controller to the grid store.
  typedef struct packed {
    logic  we;
    addr_t waddr;
    cell_t wdata;
    logic  re;
    addr_t raddr;
  } ram_req_t;

  // Control of the two line stepping units.
  typedef struct packed {
    logic load;
    logic adv;
  } step_ctl_t;

  typedef logic [REM_W-1:0] rem_t;
  typedef coord_t quo_tab_t [COORD_N];
  typedef rem_t   rem_tab_t [COORD_N];

  // Whole part of |d| / GRID_SIZE for every six-bit magnitude.
  function automatic quo_tab_t make_quo_tab();
    quo_tab_t t;
    for (int k = 0; k < COORD_N; k++) begin
      t[k] = COORD_W'(k / GRID_SIZE);
    end
    return t;
  endfunction

  // What is left of 2|d| once whole steps of 2 * GRID_SIZE are taken out.
  function automatic rem_tab_t make_rem_tab();
    rem_tab_t t;
    for (int k = 0; k < COORD_N; k++) begin
      t[k] = REM_W'(2 * (k % GRID_SIZE));
    end
    return t;
  endfunction

  localparam quo_tab_t QUO_TAB = make_quo_tab();
  localparam rem_tab_t REM_TAB = make_rem_tab();

  localparam rem_t HALF_STEP = REM_W'(GRID_SIZE);
  localparam rem_t FULL_STEP = REM_W'(2 * GRID_SIZE);

  // A reserved state code is stored and reported as free.
  function automatic cell_t norm_state(cell_t s);
    return (s == STATE_RSVD) ? STATE_FREE : s;
  endfunction

  function automatic logic cell_inside(coord_t x, coord_t y);
    return (int'(x) < GRID_SIZE) && (int'(y) < GRID_SIZE);
  endfunction

  function automatic addr_t cell_addr(coord_t x, coord_t y);
    return ADDR_W'(int'(y) * GRID_SIZE + int'(x));
  endfunction

endpackage

>>> rtl/core/ogl_grid_ram.sv
// Grid store: one synchronous memory of two-bit cells, one write and one read port.
// Read data is registered and appears in the cycle after the read request. Depends on ogl_pkg.
module ogl_grid_ram (
  input  logic             clk,
  input  ogl_pkg::ram_req_t req,
  output ogl_pkg::cell_t   rdata
);

  ogl_pkg::cell_t mem [ogl_pkg::DEPTH];
  ogl_pkg::cell_t rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/ogl_axis_step.sv
// One axis of the line stepper: walks start + round(d * i / GRID_SIZE) for rising i,
// with ties away from zero, using an accumulator instead of a division. Depends on ogl_pkg.
module ogl_axis_step (
  input  logic               clk,
  input  ogl_pkg::step_ctl_t ctl,
  input  ogl_pkg::coord_t    start_pos,
  input  ogl_pkg::coord_t    end_pos,
  output ogl_pkg::coord_t    coord
);

  // The accumulator holds 2|d|i + GRID_SIZE as q * 2 * GRID_SIZE + r.
  ogl_pkg::coord_t base_r, base_nxt;
  logic            neg_r, neg_nxt;
  ogl_pkg::coord_t aq_r, aq_nxt;
  ogl_pkg::rem_t   ar_r, ar_nxt;
  ogl_pkg::coord_t q_r, q_nxt;
  ogl_pkg::rem_t   r_r, r_nxt;

  logic            neg_in;
  ogl_pkg::coord_t mag;
  ogl_pkg::coord_t op_q;
  ogl_pkg::coord_t op_aq;
  ogl_pkg::rem_t   op_r;
  ogl_pkg::rem_t   op_ar;
  ogl_pkg::rem_t   acc;
  logic            wrap;

  // Magnitude and direction of the span on this axis.
  assign neg_in = end_pos < start_pos;
  assign mag    = neg_in ? (start_pos - end_pos) : (end_pos - start_pos);

  // On load the step is taken from the point at i = 0, so the unit holds i = 1.
  assign op_q  = ctl.load ? '0 : q_r;
  assign op_r  = ctl.load ? ogl_pkg::HALF_STEP : r_r;
  assign op_aq = ctl.load ? ogl_pkg::QUO_TAB[mag] : aq_r;
  assign op_ar = ctl.load ? ogl_pkg::REM_TAB[mag] : ar_r;

  // One step: add the fixed increment and carry once past 2 * GRID_SIZE.
  always_comb begin
    acc   = op_r + op_ar;
    wrap  = acc >= ogl_pkg::FULL_STEP;
    q_nxt = op_q + op_aq + ogl_pkg::COORD_W'(wrap);
    r_nxt = wrap ? (acc - ogl_pkg::FULL_STEP) : acc;
  end

  // Span registers are taken when a line starts.
  always_comb begin
    base_nxt = ctl.load ? start_pos : base_r;
    neg_nxt  = ctl.load ? neg_in : neg_r;
    aq_nxt   = op_aq;
    ar_nxt   = op_ar;
  end

  always_ff @(posedge clk) begin
    if (ctl.load || ctl.adv) begin
      base_r <= base_nxt;
      neg_r  <= neg_nxt;
      aq_r   <= aq_nxt;
      ar_r   <= ar_nxt;
      q_r    <= q_nxt;
      r_r    <= r_nxt;
    end
  end

  // The point always lies between start and end, so six bits hold it.
  assign coord = neg_r ? (base_r - q_r) : (base_r + q_r);

endmodule

>>> rtl/core/ogl_ctrl.sv
// Controller of the occupancy grid: clearing pass, request decoding, line sequencing
// and the result word register. Depends on ogl_pkg.
module ogl_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  ogl_pkg::func_t     func,
  input  ogl_pkg::coord_t    start_x,
  input  ogl_pkg::coord_t    start_y,
  input  ogl_pkg::coord_t    end_x,
  input  ogl_pkg::coord_t    end_y,
  input  ogl_pkg::cell_t     new_state,
  input  ogl_pkg::coord_t    pt_x,
  input  ogl_pkg::coord_t    pt_y,
  output ogl_pkg::step_ctl_t step_ctl,
  output ogl_pkg::ram_req_t  ram_req,
  input  ogl_pkg::cell_t     ram_rdata,
  output logic               out_tvalid,
  input  logic               out_tready,
  output ogl_pkg::cell_t     cell_value
);

  localparam ogl_pkg::addr_t ADDR_LAST = ogl_pkg::ADDR_W'(ogl_pkg::DEPTH - 1);
  localparam logic [ogl_pkg::CNT_W-1:0] CNT_LAST = ogl_pkg::CNT_W'(ogl_pkg::GRID_SIZE - 1);
  localparam logic [ogl_pkg::CNT_W-1:0] CNT_FIRST = ogl_pkg::CNT_W'(1);

  ogl_pkg::ctrl_state_t state_r, state_nxt;
  ogl_pkg::addr_t       clr_addr_r, clr_addr_nxt;
  logic [ogl_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  ogl_pkg::cell_t       res_r, res_nxt;
  logic                 rd_inside_r, rd_inside_nxt;
  ogl_pkg::cell_t       st_r, st_nxt;
  ogl_pkg::coord_t      ex_r, ex_nxt;
  ogl_pkg::coord_t      ey_r, ey_nxt;
  logic                 out_valid_r, out_valid_nxt;
  ogl_pkg::cell_t       out_value_r, out_value_nxt;

  logic           accept;
  logic           push;
  ogl_pkg::cell_t st_in;

  assign st_in  = ogl_pkg::norm_state(new_state);
  assign accept = in_tvalid && in_tready;
  assign push   = (state_r == ogl_pkg::ST_FINISH) && (!out_valid_r || out_tready);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ogl_pkg::ST_CLEAR: begin
        if (clr_addr_r == ADDR_LAST) begin
          state_nxt = ogl_pkg::ST_IDLE;
        end
      end
      ogl_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (func)
            ogl_pkg::FN_READ: state_nxt = ogl_pkg::ST_READ;
            ogl_pkg::FN_DRAW: state_nxt = ogl_pkg::ST_LINE;
            default:          state_nxt = ogl_pkg::ST_FINISH;
          endcase
        end
      end
      ogl_pkg::ST_READ:   state_nxt = ogl_pkg::ST_FINISH;
      ogl_pkg::ST_LINE: begin
        if (cnt_r == CNT_LAST) begin
          state_nxt = ogl_pkg::ST_END;
        end
      end
      ogl_pkg::ST_END:    state_nxt = ogl_pkg::ST_FINISH;
      ogl_pkg::ST_FINISH: begin
        if (push) begin
          state_nxt = ogl_pkg::ST_IDLE;
        end
      end
      default:            state_nxt = ogl_pkg::ST_CLEAR;
    endcase
  end

  // Memory requests and stepper control for each state.
  always_comb begin
    in_tready       = 1'b0;
    ram_req         = '0;
    step_ctl        = '0;
    unique case (state_r)
      ogl_pkg::ST_CLEAR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = clr_addr_r;
        ram_req.wdata = ogl_pkg::STATE_FREE;
      end
      ogl_pkg::ST_IDLE: begin
        in_tready     = 1'b1;
        ram_req.raddr = ogl_pkg::cell_addr(start_x, start_y);
        ram_req.waddr = ogl_pkg::cell_addr(start_x, start_y);
        ram_req.wdata = st_in;
        if (accept) begin
          // A line's first point is its start cell, written here.
          case (func)
            ogl_pkg::FN_READ:  ram_req.re = 1'b1;
            ogl_pkg::FN_WRITE: ram_req.we = ogl_pkg::cell_inside(start_x, start_y);
            ogl_pkg::FN_DRAW: begin
              ram_req.we    = ogl_pkg::cell_inside(start_x, start_y);
              step_ctl.load = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ogl_pkg::ST_LINE: begin
        ram_req.we    = ogl_pkg::cell_inside(pt_x, pt_y);
        ram_req.waddr = ogl_pkg::cell_addr(pt_x, pt_y);
        ram_req.wdata = st_r;
        step_ctl.adv  = 1'b1;
      end
      ogl_pkg::ST_END: begin
        ram_req.we    = ogl_pkg::cell_inside(ex_r, ey_r);
        ram_req.waddr = ogl_pkg::cell_addr(ex_r, ey_r);
        ram_req.wdata = st_r;
      end
      ogl_pkg::ST_READ, ogl_pkg::ST_FINISH: ;
      default: ;
    endcase
  end

  // Datapath register next values.
  always_comb begin
    clr_addr_nxt  = clr_addr_r;
    cnt_nxt       = cnt_r;
    res_nxt       = res_r;
    rd_inside_nxt = rd_inside_r;
    st_nxt        = st_r;
    ex_nxt        = ex_r;
    ey_nxt        = ey_r;

    if (state_r == ogl_pkg::ST_CLEAR) begin
      clr_addr_nxt = clr_addr_r + ogl_pkg::ADDR_W'(1);
    end

    if (accept) begin
      cnt_nxt       = CNT_FIRST;
      rd_inside_nxt = ogl_pkg::cell_inside(start_x, start_y);
      st_nxt        = st_in;
      ex_nxt        = end_x;
      ey_nxt        = end_y;
      case (func)
        ogl_pkg::FN_WRITE, ogl_pkg::FN_DRAW: res_nxt = st_in;
        default:                             res_nxt = ogl_pkg::STATE_FREE;
      endcase
    end

    if (state_r == ogl_pkg::ST_LINE) begin
      cnt_nxt = cnt_r + ogl_pkg::CNT_W'(1);
    end

    // A read outside the grid answers free.
    if (state_r == ogl_pkg::ST_READ) begin
      res_nxt = rd_inside_r ? ram_rdata : ogl_pkg::STATE_FREE;
    end
  end

  // Result word register: taken while the slot is empty or being drained.
  always_comb begin
    out_value_nxt = push ? res_r : out_value_r;
    if (push) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ogl_pkg::ST_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cnt_r       <= cnt_nxt;
    res_r       <= res_nxt;
    rd_inside_r <= rd_inside_nxt;
    st_r        <= st_nxt;
    ex_r        <= ex_nxt;
    ey_r        <= ey_nxt;
    out_value_r <= out_value_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign cell_value = out_value_r;

endmodule

>>> rtl/core/occupancy_grid_line_draw.sv
// Occupancy grid with line drawing. Each input word is one request: read a cell, write
// a cell, or draw a line of cells in one state; each request gives one result word.
// After reset the block first clears the grid with a pass over all GRID_SIZE * GRID_SIZE
// cells (4096 at a 64-cell side) and accepts no word until it is done. A read then goes
// through a read state and a finish state, a write or an unknown request straight to the
// finish state, and a line draw through the line states and an end state, one word at a
// time; the finish state places the result word in the output register. A line draw is
// paced by the single write port of the grid memory, which stores one line point per cycle. A new
// word is taken once the previous result has been placed in the output register.
// Depends on ogl_pkg, ogl_grid_ram, ogl_axis_step and ogl_ctrl.
module occupancy_grid_line_draw (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // func[1:0], start_x[7:2], start_y[13:8], end_x[19:14], end_y[25:20],
  // new_state[27:26], zero[31:28]
  input  logic [31:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // cell_value[1:0], zero[7:2]
  output logic [7:0]  out_tdata
);

  ogl_pkg::func_t     func;
  ogl_pkg::coord_t    start_x, start_y, end_x, end_y;
  ogl_pkg::cell_t     new_state;
  ogl_pkg::coord_t    pt_x, pt_y;
  ogl_pkg::step_ctl_t step_ctl;
  ogl_pkg::ram_req_t  ram_req;
  ogl_pkg::cell_t     ram_rdata;
  ogl_pkg::cell_t     cell_value;

  // Unpack the input word.
  assign func      = in_tdata[1:0];
  assign start_x   = in_tdata[7:2];
  assign start_y   = in_tdata[13:8];
  assign end_x     = in_tdata[19:14];
  assign end_y     = in_tdata[25:20];
  assign new_state = in_tdata[27:26];

  ogl_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .func       (func),
    .start_x    (start_x),
    .start_y    (start_y),
    .end_x      (end_x),
    .end_y      (end_y),
    .new_state  (new_state),
    .pt_x       (pt_x),
    .pt_y       (pt_y),
    .step_ctl   (step_ctl),
    .ram_req    (ram_req),
    .ram_rdata  (ram_rdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cell_value (cell_value)
  );

  // Line point generators, one per axis.
  ogl_axis_step u_step_x (
    .clk       (clk),
    .ctl       (step_ctl),
    .start_pos (start_x),
    .end_pos   (end_x),
    .coord     (pt_x)
  );

  ogl_axis_step u_step_y (
    .clk       (clk),
    .ctl       (step_ctl),
    .start_pos (start_y),
    .end_pos   (end_y),
    .coord     (pt_y)
  );

  ogl_grid_ram u_grid (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  // Pack the result word.
  assign out_tdata = {6'b0, cell_value};

endmodule

>>> tb/grid_model_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the occupancy grid testbench: a shadow copy of the grid that predicts
// the result word of every accepted request and checks the words that come back.
// Depends on ogl_pkg for the grid geometry, the cell type and the request codes.
package grid_model_pkg;
  import ogl_pkg::*;

  // Codes that the block's package leaves without a name.
  localparam func_t FN_UNKNOWN     = 2'd3;
  localparam cell_t STATE_AGENT    = 2'd1;
  localparam cell_t STATE_OBSTACLE = 2'd2;

  localparam int REPORT_LIMIT = 10;

  class grid_scoreboard;
    cell_t cells [DEPTH];
    cell_t cell_value_q [$];
    int    errors;

    function new();
      foreach (cells[k]) cells[k] = STATE_FREE;
      errors = 0;
    endfunction

    // Nearest whole number to d * i / GRID_SIZE, with halves going away from zero.
    static function int scaled_step(int d, int i);
      int prod;
      int mag;
      int q;
      prod = d * i;
      mag  = (prod < 0) ? -prod : prod;
      q    = (2 * mag + GRID_SIZE) / (2 * GRID_SIZE);
      return (prod < 0) ? -q : q;
    endfunction

    // Point i of the line from the start cell towards the end cell.
    static function void line_point(int sx, int sy, int ex, int ey, int i,
                                    output int px, output int py);
      px = sx + scaled_step(ex - sx, i);
      py = sy + scaled_step(ey - sy, i);
    endfunction

    // Cells off the grid are silently dropped.
    function void store(int x, int y, cell_t s);
      if (x < GRID_SIZE && y < GRID_SIZE) cells[y * GRID_SIZE + x] = s;
    endfunction

    // Applies an accepted request word to the shadow grid and queues its result.
    function void note_request(logic [31:0] w);
      func_t fn;
      int    sx;
      int    sy;
      int    ex;
      int    ey;
      int    px;
      int    py;
      cell_t st;
      cell_t result;
      fn = w[1:0];
      sx = int'(w[7:2]);
      sy = int'(w[13:8]);
      ex = int'(w[19:14]);
      ey = int'(w[25:20]);
      st = w[27:26];
      // The reserved state code is written and reported as free.
      if (st == STATE_RSVD) st = STATE_FREE;
      result = STATE_FREE;
      case (fn)
        FN_READ: begin
          if (sx < GRID_SIZE && sy < GRID_SIZE) result = cells[sy * GRID_SIZE + sx];
        end
        FN_WRITE: begin
          store(sx, sy, st);
          result = st;
        end
        FN_DRAW: begin
          for (int i = 0; i < GRID_SIZE; i++) begin
            line_point(sx, sy, ex, ey, i, px, py);
            store(px, py, st);
          end
          store(ex, ey, st);
          result = st;
        end
        default: begin
          // An unknown request leaves the grid alone and answers free.
        end
      endcase
      cell_value_q = {cell_value_q, result};
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= REPORT_LIMIT) $display("mismatch: %s", msg);
    endfunction

    // Compares a result word with the oldest outstanding prediction.
    function void check_result(logic [7:0] w);
      cell_t want;
      if (cell_value_q.size() == 0) begin
        flag($sformatf("result word %h arrived with no request outstanding", w));
        return;
      end
      want = cell_value_q.pop_front();
      if (w[1:0] !== want)
        flag($sformatf("cell_value expected %0d, got %0d", want, w[1:0]));
      if (w[7:2] !== 6'd0)
        flag($sformatf("padding expected 00, got %h", w[7:2]));
    endfunction

    function int pending();
      return cell_value_q.size();
    endfunction
  endclass

endpackage

>>> tb/tb_occupancy_grid_line_draw.sv
`timescale 1ns / 100ps
// Testbench for occupancy_grid_line_draw: directed and random read, write and line draw
// requests under varying idle and stall patterns, checked word by word by a scoreboard.
// Depends on ogl_pkg, grid_model_pkg and the occupancy_grid_line_draw RTL.
module tb_occupancy_grid_line_draw;
  import ogl_pkg::*;
  import grid_model_pkg::*;

  localparam int RESET_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 80;
  localparam int HOLD_CYCLES  = 400;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;

  grid_scoreboard sb;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  logic long_hold = 1'b0;
  logic pressure_go = 1'b0;
  int   cycle_count = 0;

  // Last line drawn at random, so that reads can land on its cells.
  int last_sx = 0;
  int last_sy = 0;
  int last_ex = 0;
  int last_ey = 0;

  occupancy_grid_line_draw dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit, well above the slowest correct run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_occupancy_grid_line_draw NOT OK");
      $finish;
    end
  end

  // Result side: checks every accepted word and stalls at random or for a long hold.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
    out_tready <= !long_hold && ($urandom_range(99) >= recv_stall_pct);
  end

  // Long hold on the result side, so that the block fills up and stalls its input.
  initial begin
    wait (pressure_go);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    long_hold <= 1'b0;
  end

  function automatic logic [31:0] pack_request(func_t fn, int sx, int sy,
                                               int ex, int ey, cell_t st);
    return {4'd0, st, coord_t'(ey), coord_t'(ex), coord_t'(sy), coord_t'(sx), fn};
  endfunction

  // Offers one request word and returns at the edge where it is taken.
  task automatic send_word(input logic [31:0] w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= w;
    do @(posedge clk); while (!in_tready);
    sb.note_request(w);
  endtask

  // Mostly reads, writes and line draws with random content; a few unknown requests.
  function automatic logic [31:0] random_request();
    int    pick;
    int    px;
    int    py;
    int    sx;
    int    sy;
    int    ex;
    int    ey;
    cell_t st;
    pick = $urandom_range(99);
    sx = $urandom_range(COORD_N - 1);
    sy = $urandom_range(COORD_N - 1);
    ex = $urandom_range(COORD_N - 1);
    ey = $urandom_range(COORD_N - 1);
    st = cell_t'($urandom_range(3));
    if (pick < 35) begin
      last_sx = sx;
      last_sy = sy;
      last_ex = ex;
      last_ey = ey;
      return pack_request(FN_DRAW, sx, sy, ex, ey, st);
    end else if (pick < 55) begin
      return pack_request(FN_WRITE, sx, sy, ex, ey, st);
    end else if (pick < 95) begin
      // Half of the reads look at a cell of the last line drawn.
      if ($urandom_range(1) == 1) begin
        grid_scoreboard::line_point(last_sx, last_sy, last_ex, last_ey,
                                    $urandom_range(GRID_SIZE - 1), px, py);
        sx = px;
        sy = py;
      end
      return pack_request(FN_READ, sx, sy, ex, ey, st);
    end
    return pack_request(FN_UNKNOWN, sx, sy, ex, ey, st);
  endfunction

  task automatic run_phase(input int n, input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct <= recv_pct;
    repeat (n) send_word(random_request());
  endtask

  initial begin
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Corners of the grid, every state code including the reserved one.
    send_word(pack_request(FN_READ, 0, 0, 0, 0, STATE_FREE));
    send_word(pack_request(FN_READ, 63, 63, 0, 0, STATE_FREE));
    send_word(pack_request(FN_WRITE, 0, 0, 0, 0, STATE_AGENT));
    send_word(pack_request(FN_WRITE, 63, 63, 0, 0, STATE_OBSTACLE));
    send_word(pack_request(FN_WRITE, 63, 0, 0, 0, STATE_RSVD));
    send_word(pack_request(FN_READ, 0, 0, 0, 0, STATE_FREE));
    send_word(pack_request(FN_READ, 63, 63, 0, 0, STATE_FREE));
    // Unknown request with every field bit set.
    send_word(pack_request(FN_UNKNOWN, 63, 63, 63, 63, STATE_RSVD));
    send_word(pack_request(FN_READ, 63, 0, 0, 0, STATE_FREE));
    // Full row, reversed column, both diagonals and a single-cell line.
    send_word(pack_request(FN_DRAW, 0, 0, 63, 0, STATE_OBSTACLE));
    send_word(pack_request(FN_READ, 32, 0, 0, 0, STATE_FREE));
    send_word(pack_request(FN_DRAW, 0, 63, 0, 0, STATE_AGENT));
    send_word(pack_request(FN_DRAW, 0, 0, 63, 63, STATE_OBSTACLE));
    send_word(pack_request(FN_READ, 31, 31, 0, 0, STATE_FREE));
    send_word(pack_request(FN_DRAW, 63, 0, 0, 63, STATE_AGENT));
    send_word(pack_request(FN_DRAW, 10, 10, 10, 10, STATE_OBSTACLE));
    send_word(pack_request(FN_READ, 10, 10, 0, 0, STATE_FREE));
    // A one-cell step in x and y lands exactly on a half at the midpoint.
    send_word(pack_request(FN_DRAW, 20, 20, 21, 19, STATE_AGENT));
    send_word(pack_request(FN_READ, 21, 19, 0, 0, STATE_FREE));
    send_word(pack_request(FN_READ, 20, 20, 0, 0, STATE_FREE));
    // Lines drawn with the reserved code clear their cells.
    send_word(pack_request(FN_DRAW, 5, 40, 60, 2, STATE_RSVD));
    send_word(pack_request(FN_READ, 5, 40, 0, 0, STATE_FREE));
    send_word(pack_request(FN_DRAW, 0, 0, 63, 0, STATE_RSVD));
    send_word(pack_request(FN_READ, 63, 0, 0, 0, STATE_FREE));

    run_phase(130, 0, 0);
    run_phase(130, 51, 0);
    run_phase(130, 0, 51);
    run_phase(110, 11, 11);

    // Keep offering words while the result side holds off.
    pressure_go = 1'b1;
    run_phase(30, 0, 0);
    in_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb_occupancy_grid_line_draw OK");
    end else begin
      $display("tb_occupancy_grid_line_draw NOT OK");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/ogl_pkg.sv
rtl/core/ogl_grid_ram.sv
rtl/core/ogl_axis_step.sv
rtl/core/ogl_ctrl.sv
rtl/core/occupancy_grid_line_draw.sv
tb/grid_model_pkg.sv
tb/tb_occupancy_grid_line_draw.sv
